FILE: rtl/hlps_pkg.sv
// Package for the hit lockout pulse sequencer: phase codes, config and result
// structs, switch pattern tables. No dependencies.
`timescale 1ns / 1ps

package hlps_pkg;

  typedef enum logic [1:0] {
    PH_ARMED = 2'd0,
    PH_HIT   = 2'd1,
    PH_COOL  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_HIT_TIME  = 2'd0,
    REG_COOLDOWN  = 2'd1,
    REG_PAT_SEL   = 2'd2,
    REG_CHAN_MASK = 2'd3
  } reg_idx_t;

  localparam int unsigned CFG_W = 16;

  typedef struct packed {
    logic [15:0] hit_len;
    logic [15:0] cool_len;
    logic        pattern_select;
    logic [2:0]  channel_mask;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] shooter;
    logic [7:0] damage;
    logic       test_mode;
  } req_t;

  typedef struct packed {
    logic [2:0] switch_lines;
    phase_t     phase;
    logic       report_valid;
    logic [7:0] report_shooter;
    logic [7:0] report_damage;
  } res_t;

  function automatic logic [2:0] pat_len(input logic p);
    pat_len = p ? 3'd6 : 3'd2;
  endfunction

  function automatic logic pat_on(input logic p, input logic [2:0] s);
    logic on;
    on = 1'b0;
    if (p) begin
      on = (s == 3'd0) || (s == 3'd2) || (s == 3'd4);
    end else begin
      on = (s == 3'd0);
    end
    pat_on = on;
  endfunction

  function automatic logic [15:0] step_time(input logic p, input logic [2:0] s,
                                            input logic [15:0] hit_len);
    logic [15:0] t;
    t = 16'd0;
    if (!p) begin
      t = (s == 3'd0) ? hit_len : 16'd0;
    end else begin
      case (s)
        3'd0:    t = 16'd700;
        3'd1:    t = 16'd200;
        3'd2:    t = 16'd200;
        3'd3:    t = 16'd200;
        3'd4:    t = 16'd200;
        default: t = 16'd0;
      endcase
    end
    step_time = t;
  endfunction

endpackage

FILE: rtl/hlps_seq.sv
// Phase, timer and pattern state of the hit sequencer with its next-state logic.
// Depends on hlps_pkg.
`timescale 1ns / 1ps

module hlps_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  hlps_pkg::req_t req,
  input  hlps_pkg::cfg_t cfg,
  output hlps_pkg::res_t res
);

  hlps_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] prem_r, prem_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [15:0] srem_r, srem_nxt;
  logic [2:0]  sw_r, sw_nxt;

  logic [2:0] step_inc;
  logic       rep;

  always_comb begin
    phase_nxt = phase_r;
    prem_nxt  = prem_r;
    step_nxt  = step_r;
    srem_nxt  = srem_r;
    sw_nxt    = sw_r;
    rep       = 1'b0;
    step_inc  = 3'd0;

    // tick or hit
    if (!req.command) begin
      if (prem_nxt != 16'd0) prem_nxt = prem_nxt - 16'd1;
      if (srem_nxt != 16'd0) srem_nxt = srem_nxt - 16'd1;
    end else if (!req.test_mode && phase_r == hlps_pkg::PH_ARMED) begin
      phase_nxt = hlps_pkg::PH_HIT;
      prem_nxt  = cfg.hit_len;
      rep       = 1'b1;
      step_nxt  = 3'd0;
      srem_nxt  = hlps_pkg::step_time(cfg.pattern_select, 3'd0, cfg.hit_len);
      sw_nxt    = hlps_pkg::pat_on(cfg.pattern_select, 3'd0) ? cfg.channel_mask : 3'd0;
    end

    // end of phase
    if (phase_nxt == hlps_pkg::PH_HIT && prem_nxt == 16'd0) begin
      if (cfg.cool_len != 16'd0) begin
        phase_nxt = hlps_pkg::PH_COOL;
        prem_nxt  = cfg.cool_len;
      end else begin
        phase_nxt = hlps_pkg::PH_ARMED;
      end
      sw_nxt = 3'd0;
    end else if (phase_nxt == hlps_pkg::PH_COOL && prem_nxt == 16'd0) begin
      phase_nxt = hlps_pkg::PH_ARMED;
      sw_nxt    = 3'd0;
    end

    // advance pattern
    if (phase_nxt == hlps_pkg::PH_HIT && step_nxt < hlps_pkg::pat_len(cfg.pattern_select)
        && srem_nxt == 16'd0) begin
      step_inc = step_nxt + 3'd1;
      step_nxt = step_inc;
      if (step_inc >= hlps_pkg::pat_len(cfg.pattern_select)) begin
        sw_nxt = 3'd0;
      end else begin
        sw_nxt   = hlps_pkg::pat_on(cfg.pattern_select, step_inc) ? cfg.channel_mask : 3'd0;
        srem_nxt = hlps_pkg::step_time(cfg.pattern_select, step_inc, cfg.hit_len);
      end
    end

    res.switch_lines   = sw_nxt;
    res.phase          = phase_nxt;
    res.report_valid   = rep;
    res.report_shooter = rep ? req.shooter : 8'd0;
    res.report_damage  = rep ? req.damage : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hlps_pkg::PH_ARMED;
      prem_r  <= 16'd0;
      step_r  <= 3'd0;
      srem_r  <= 16'd0;
      sw_r    <= 3'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      prem_r  <= prem_nxt;
      step_r  <= step_nxt;
      srem_r  <= srem_nxt;
      sw_r    <= sw_nxt;
    end
  end

endmodule

FILE: rtl/hit_lockout_pulse_sequencer_top.sv
// Path: a request accepted into the input register is loaded into the result register
// when the output register is free or taken. Throughput: one request per cycle;
// the input stalls only while both registers hold and the output is stalled.
// Synchronous active-low reset sets phase armed, timers and switch lines to zero
// and config to its defaults.
// Top level of the hit lockout pulse sequencer. Depends on hlps_pkg, hlps_seq.
`timescale 1ns / 1ps

module hit_lockout_pulse_sequencer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [hlps_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [7:0]                 in_shooter,
  input  logic [7:0]                 in_damage,
  input  logic                       in_test_mode,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_switch_lines,
  output logic [1:0]                 out_phase,
  output logic                       out_report_valid,
  output logic [7:0]                 out_report_shooter,
  output logic [7:0]                 out_report_damage
);

  hlps_pkg::cfg_t cfg_r;
  hlps_pkg::req_t req_r;
  hlps_pkg::res_t res, res_r;
  logic           in_v_r, out_v_r;
  logic           adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hit_len        <= 16'd1000;
      cfg_r.cool_len       <= 16'd1000;
      cfg_r.pattern_select <= 1'b0;
      cfg_r.channel_mask   <= 3'd7;
    end else if (cfg_we) begin
      unique case (hlps_pkg::reg_idx_t'(cfg_index))
        hlps_pkg::REG_HIT_TIME:  cfg_r.hit_len        <= cfg_wdata;
        hlps_pkg::REG_COOLDOWN:  cfg_r.cool_len       <= cfg_wdata;
        hlps_pkg::REG_PAT_SEL:   cfg_r.pattern_select <= cfg_wdata[0];
        hlps_pkg::REG_CHAN_MASK: cfg_r.channel_mask   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      req_r.command   <= in_command;
      req_r.shooter   <= in_shooter;
      req_r.damage    <= in_damage;
      req_r.test_mode <= in_test_mode;
    end
  end

  hlps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (req_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_switch_lines   = res_r.switch_lines;
  assign out_phase          = res_r.phase;
  assign out_report_valid   = res_r.report_valid;
  assign out_report_shooter = res_r.report_shooter;
  assign out_report_damage  = res_r.report_damage;

  a_lines_only_in_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.switch_lines != 3'd0) |-> (res_r.phase == hlps_pkg::PH_HIT))
    else $error("switch lines driven outside hit phase");

  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !res_r.report_valid) |->
      (res_r.report_shooter == 8'd0 && res_r.report_damage == 8'd0))
    else $error("report fields set without a report");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> !(out_v_r && out_stall))
    else $error("result register overwritten while held");

endmodule
